// ===== design/ntc_pkg.sv =====
// shared types, constants and lookup tables for the ntc thermistor converter
// no dependencies; used by ntc_div and ntc_thermistor_adc_to_temp_unit
package ntc_pkg;

	localparam int ADC_W          = 12;
	localparam int ADC_FULL_SCALE = 4095;
	localparam int RES_W          = 20;
	localparam int TEMP_W         = 18;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = 3;

	localparam int TABLE_POINTS = 10;
	localparam int SEGS         = TABLE_POINTS - 1;
	localparam int SEG_W        = $clog2(SEGS);
	localparam int TAB_W        = 22;
	localparam int DT_W         = 15;
	localparam int NUM_W        = 40;
	localparam int PROD_W       = TAB_W + DT_W;

	// divider geometry: 36-bit dividend for the resistance, 22-bit divisor for the slope
	localparam int R_W        = 36;
	localparam int DIV_RW     = TAB_W;
	localparam int DIV_CW     = $clog2(R_W + 1);
	localparam int FRAC_STEPS = 17;

	localparam int RES_RESET = 10000;
	localparam logic signed [TEMP_W-1:0] T_MIN_MILLI = -18'sd40000;
	localparam logic signed [TEMP_W-1:0] T_MAX_MILLI = 18'sd120000;

	// register word index, taken from paddr[2]
	localparam logic REG_FIXED_RES = 1'b0;

	typedef logic        [TAB_W-1:0]  tab_res_arr_t  [TABLE_POINTS];
	typedef logic signed [TEMP_W-1:0] tab_temp_arr_t [TABLE_POINTS];
	typedef logic        [TAB_W-1:0]  seg_res_arr_t  [SEGS];
	typedef logic        [DT_W-1:0]   seg_dt_arr_t   [SEGS];
	typedef logic signed [NUM_W-1:0]  seg_c_arr_t    [SEGS];

	// resistance in 0.1 ohm, falling with the index
	localparam tab_res_arr_t TAB_RES = '{
		22'd3327760, 22'd964810, 22'd325660, 22'd124860, 22'd100000,
		22'd53310, 22'd24900, 22'd10710, 22'd6781, 22'd3873
	};

	// temperature in milli-degrees, rising with the index
	localparam tab_temp_arr_t TAB_TEMP = '{
		-18'sd40000, -18'sd20000, 18'sd0, 18'sd20000, 18'sd25000,
		18'sd40000, 18'sd60000, 18'sd85000, 18'sd100000, 18'sd120000
	};

	function automatic seg_res_arr_t calc_seg_rb();
		seg_res_arr_t a;
		for (int k = 0; k < SEGS; k++) begin
			a[k] = TAB_RES[k+1];
		end
		return a;
	endfunction

	function automatic seg_res_arr_t calc_seg_dr();
		seg_res_arr_t a;
		for (int k = 0; k < SEGS; k++) begin
			a[k] = TAB_RES[k] - TAB_RES[k+1];
		end
		return a;
	endfunction

	function automatic seg_dt_arr_t calc_seg_dt();
		seg_dt_arr_t a;
		for (int k = 0; k < SEGS; k++) begin
			a[k] = DT_W'(TAB_TEMP[k+1] - TAB_TEMP[k]);
		end
		return a;
	endfunction

	// upper temperature times resistance span of each segment
	function automatic seg_c_arr_t calc_seg_c();
		seg_c_arr_t a;
		for (int k = 0; k < SEGS; k++) begin
			a[k] = NUM_W'(longint'(TAB_TEMP[k+1]) * longint'(TAB_RES[k] - TAB_RES[k+1]));
		end
		return a;
	endfunction

	localparam seg_res_arr_t SEG_RB = calc_seg_rb();
	localparam seg_res_arr_t SEG_DR = calc_seg_dr();
	localparam seg_dt_arr_t  SEG_DT = calc_seg_dt();
	localparam seg_c_arr_t   SEG_C  = calc_seg_c();

	typedef struct packed {
		logic              load;
		logic [DIV_CW-1:0] steps;
		logic [DIV_RW-1:0] rem_init;
		logic [R_W-1:0]    quo_init;
		logic [DIV_RW-1:0] divisor;
	} div_req_t;

endpackage

// ===== design/ntc_div.sv =====
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on ntc_pkg for widths and the request struct
module ntc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ntc_pkg::div_req_t req,
	output logic              done,
	output logic [ntc_pkg::R_W-1:0] quotient
);

	localparam int RW = ntc_pkg::DIV_RW;
	localparam int QW = ntc_pkg::R_W;
	localparam int CW = ntc_pkg::DIV_CW;

	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW+1:0] trial;
	logic          ge;

	// partial remainder stays below the divisor, so one subtract decides the bit
	assign trial = {1'b0, rem_q, quo_q[QW-1]} - {2'b00, dvs_q};
	assign ge    = ~trial[RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.load) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			rem_q <= req.rem_init;
			quo_q <= req.quo_init;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial[RW-1:0] : {rem_q[RW-2:0], quo_q[QW-1]};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/ntc_thermistor_adc_to_temp_unit.sv =====
// top level of the ntc thermistor adc-to-temperature converter
// depends on ntc_pkg and ntc_div
//
// usage:
//   command channel: raise start with adc_sample; the transfer happens at the
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been produced.
//   result channel: done pulses for exactly one cycle with temperature_milli_c
//   (signed milli-degrees celsius, -40000 to 120000). the receiver cannot
//   stall, so the result must be captured in that cycle.
//   config: apb-style port, one register fixed_resistor_ohm at byte address 0,
//   reset value 10000; write only while the block is idle. pready is always 1.
// sequence:
//   a regular sample passes through prep, resistance division (36 quotient
//   bits), segment search, multiply, numerator setup and interpolation
//   division (17 quotient bits) before done is raised; the shared divider
//   produces one quotient bit per cycle. a resistance outside the table
//   raises done after the search, a zero or full-scale sample after prep.
//   a new transfer can be taken in the done cycle.
// reset: asynchronous, active low; the sequencer returns to idle, no result
//   pending, and the register returns to 10000
module ntc_thermistor_adc_to_temp_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             start,
	output logic                             busy,
	input  logic [ntc_pkg::ADC_W-1:0]        adc_sample,
	// result channel
	output logic                             done,
	output logic signed [ntc_pkg::TEMP_W-1:0] temperature_milli_c,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ntc_pkg::ADDR_W-1:0]       paddr,
	input  logic [ntc_pkg::DATA_W-1:0]       pwdata,
	output logic [ntc_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);

	localparam int ADC_W  = ntc_pkg::ADC_W;
	localparam int RES_W  = ntc_pkg::RES_W;
	localparam int TEMP_W = ntc_pkg::TEMP_W;
	localparam int R_W    = ntc_pkg::R_W;
	localparam int TAB_W  = ntc_pkg::TAB_W;
	localparam int SEG_W  = ntc_pkg::SEG_W;
	localparam int SEGS   = ntc_pkg::SEGS;
	localparam int NUM_W  = ntc_pkg::NUM_W;
	localparam int PROD_W = ntc_pkg::PROD_W;
	localparam int FRAC   = ntc_pkg::FRAC_STEPS;
	localparam int RW     = ntc_pkg::DIV_RW;
	localparam int CW     = ntc_pkg::DIV_CW;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_DIV1 = 7'b0000100,
		ST_SRCH = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_NUM  = 7'b0100000,
		ST_DIV2 = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic [RES_W-1:0]           fixed_res_q;
	logic [ADC_W-1:0]           adc_q;
	logic [R_W-1:0]             r_q;
	logic [SEG_W-1:0]           seg_q;
	logic [TAB_W-1:0]           rd_q;
	logic [PROD_W-1:0]          prod_q;
	logic                       neg_q;
	logic signed [TEMP_W-1:0]   temp_q;
	logic                       done_q;

	// config write and read
	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_res_q <= RES_W'(ntc_pkg::RES_RESET);
		end else if (cfg_wr && paddr[2] == ntc_pkg::REG_FIXED_RES) begin
			fixed_res_q <= pwdata[RES_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == ntc_pkg::REG_FIXED_RES) begin
			prdata = {{(ntc_pkg::DATA_W-RES_W){1'b0}}, fixed_res_q};
		end
	end

	// sample classification
	logic adc_zero;
	logic adc_full;
	assign adc_zero = (adc_q == '0);
	assign adc_full = (adc_q >= ADC_W'(ntc_pkg::ADC_FULL_SCALE));

	// resistance numerator: fixed_res * 10 * (full_scale - adc)
	logic [ADC_W-1:0] adc_diff;
	logic [R_W-1:0]   res10;
	logic [R_W-1:0]   res_num;
	assign adc_diff = ADC_W'(ntc_pkg::ADC_FULL_SCALE) - adc_q;
	assign res10    = ({{(R_W-RES_W){1'b0}}, fixed_res_q} << 3)
	                + ({{(R_W-RES_W){1'b0}}, fixed_res_q} << 1);
	assign res_num  = res10 * {{(R_W-ADC_W){1'b0}}, adc_diff};

	// segment search against the constant table, lowest matching segment wins
	logic             above_tab;
	logic             seg_hit;
	logic [SEG_W-1:0] seg_sel;
	assign above_tab = (r_q > {{(R_W-TAB_W){1'b0}}, ntc_pkg::TAB_RES[0]});

	always_comb begin
		seg_hit = 1'b0;
		seg_sel = '0;
		for (int k = SEGS - 1; k >= 0; k--) begin
			if (r_q <= {{(R_W-TAB_W){1'b0}}, ntc_pkg::TAB_RES[k]} &&
			    r_q >= {{(R_W-TAB_W){1'b0}}, ntc_pkg::TAB_RES[k+1]}) begin
				seg_hit = 1'b1;
				seg_sel = SEG_W'(k);
			end
		end
	end

	// interpolation numerator: t_b*dr - (r - r_b)*dt, split into sign and magnitude
	logic signed [NUM_W-1:0] interp_num;
	logic [NUM_W-1:0]        interp_mag;
	assign interp_num = ntc_pkg::SEG_C[seg_q] - $signed({{(NUM_W-PROD_W){1'b0}}, prod_q});
	assign interp_mag = interp_num[NUM_W-1] ? NUM_W'(-interp_num) : NUM_W'(interp_num);

	// shared divider
	ntc_pkg::div_req_t div_req;
	logic              div_done;
	logic [R_W-1:0]    div_quo;

	always_comb begin
		div_req = '0;
		if (state_q == ST_PREP && !adc_zero && !adc_full) begin
			div_req.load     = 1'b1;
			div_req.steps    = CW'(R_W);
			div_req.rem_init = '0;
			div_req.quo_init = res_num;
			div_req.divisor  = {{(RW-ADC_W){1'b0}}, adc_q};
		end else if (state_q == ST_NUM) begin
			// quotient is known to fit the fraction step count, so the upper
			// bits of the magnitude seed the remainder directly
			div_req.load     = 1'b1;
			div_req.steps    = CW'(FRAC);
			div_req.rem_init = interp_mag[FRAC+RW-1:FRAC];
			div_req.quo_init = {interp_mag[FRAC-1:0], {(R_W-FRAC){1'b0}}};
			div_req.divisor  = ntc_pkg::SEG_DR[seg_q];
		end
	end

	ntc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic [TEMP_W-1:0] quo_mag;
	assign quo_mag = {{(TEMP_W-FRAC){1'b0}}, div_quo[FRAC-1:0]};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (adc_zero || adc_full) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (above_tab || !seg_hit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					adc_q <= adc_sample;
				end
			end
			ST_PREP: begin
				// zero sample saturates high resistance, full scale means zero ohms
				if (adc_zero) begin
					temp_q <= ntc_pkg::T_MIN_MILLI;
				end else if (adc_full) begin
					temp_q <= ntc_pkg::T_MAX_MILLI;
				end
			end
			ST_DIV1: begin
				if (div_done) begin
					r_q <= div_quo;
				end
			end
			ST_SRCH: begin
				if (above_tab) begin
					temp_q <= ntc_pkg::T_MIN_MILLI;
				end else if (!seg_hit) begin
					temp_q <= ntc_pkg::T_MAX_MILLI;
				end else begin
					seg_q <= seg_sel;
					rd_q  <= r_q[TAB_W-1:0] - ntc_pkg::SEG_RB[seg_sel];
				end
			end
			ST_MUL: begin
				prod_q <= {{(PROD_W-TAB_W){1'b0}}, rd_q}
				        * {{(PROD_W-ntc_pkg::DT_W){1'b0}}, ntc_pkg::SEG_DT[seg_q]};
			end
			ST_NUM: begin
				neg_q <= interp_num[NUM_W-1];
			end
			ST_DIV2: begin
				// truncation toward zero: divide the magnitude, then restore the sign
				if (div_done) begin
					temp_q <= neg_q ? $signed(-quo_mag) : $signed(quo_mag);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy                = (state_q != ST_IDLE);
	assign done                = done_q;
	assign temperature_milli_c = temp_q;

endmodule
